// File: rtl/affinity_chunk_dispenser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affinity chunk dispenser
// Short wrappers for implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef AFFINITY_CHUNK_DISPENSER_ASSERT_SVH
`define AFFINITY_CHUNK_DISPENSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("acd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACD_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("acd check failed");

`endif

// File: rtl/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int IDW         = $clog2(MAX_WORKERS);
  localparam int DW          = 16;
  localparam int NWW         = 5;
  localparam int DIV_CW      = $clog2(DW + 1);

  typedef logic [DW-1:0]  data_t;
  typedef logic [IDW-1:0] wid_t;
  typedef logic [NWW-1:0] nw_t;

  localparam logic REG_NUM_WORKERS = 1'b0;
  localparam logic REG_TOTAL_ITERS = 1'b1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_CHUNK = 1'b1;

  localparam nw_t   RST_NUM_WORKERS = nw_t'(4);
  localparam data_t RST_TOTAL_ITERS = data_t'(729);

  typedef enum logic [3:0] {
    S_IDLE, S_PDIV, S_FILL, S_LOAD, S_CHECK, S_SCAN, S_PICK, S_TAKE, S_RDIV, S_GRANT
  } state_t;

  typedef struct packed {
    logic latch;
    logic div_load;
    logic div_sel_rem;
    logic div_step;
    logic fill_start;
    logic fill_step;
    logic load_me;
    logic scan_step;
    logic take;
    logic grant;
    logic emit_start;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_last;
    logic me_empty;
    logic best_zero;
  } status_t;

endpackage

// File: rtl/acd_ctrl.sv
// ----------------------------------------------------------------------------
// acd_ctrl
// Sequencer for partition, own-range grant and takeover of a loaded range.
// ----------------------------------------------------------------------------
module acd_ctrl
  import acd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_req_type,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (in_req_type == REQ_START) begin
            cmd.div_load = 1'b1;
            state_nxt    = S_PDIV;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_PDIV: begin
        if (sts.div_done) begin
          cmd.fill_start = 1'b1;
          state_nxt      = S_FILL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.idx_last) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.load_me = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (sts.me_empty) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.div_load    = 1'b1;
          cmd.div_sel_rem = 1'b1;
          state_nxt       = S_RDIV;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (sts.best_zero) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.take  = 1'b1;
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.div_load    = 1'b1;
        cmd.div_sel_rem = 1'b1;
        state_nxt       = S_RDIV;
      end
      S_RDIV: begin
        if (sts.div_done) begin
          state_nxt = S_GRANT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/acd_dp.sv
// ----------------------------------------------------------------------------
// acd_dp
// Range table, config registers, serial divider, load scan and result word.
// ----------------------------------------------------------------------------
module acd_dp
  import acd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  output status_t sts,
  input  logic    in_worker_id_vld,
  input  wid_t    in_worker_id,
  input  logic    cfg_we,
  input  logic    cfg_index,
  input  data_t   cfg_wdata,
  output logic    out_valid,
  output data_t   out_chunk_start,
  output data_t   out_chunk_end,
  output logic    out_stolen,
  output wid_t    out_victim_id,
  output logic    out_all_done
);

  nw_t   num_workers_r;
  data_t total_r;
  data_t rn_r [MAX_WORKERS];
  data_t re_r [MAX_WORKERS];

  wid_t  me_r, idx_r, victim_r;
  data_t rem_r, best_r, best_next_r, best_end_r, acc_r;
  logic  stolen_r;

  logic [NWW:0]    div_pr_r;
  data_t           div_q_r;
  logic [DIV_CW-1:0] div_cnt_r;

  logic       out_valid_r, out_stolen_r, out_all_done_r;
  data_t      out_start_r, out_end_r;
  wid_t       out_victim_r;

  nw_t   p_eff;
  wid_t  rd_addr;
  data_t rd_next, rd_end, rd_load;
  logic [NWW:0] div_try;
  logic  div_ge;
  data_t chunk, s_sat;
  logic [DW:0] e_full;
  data_t e_sat;
  logic  fill_live, fill_tail;

  // Clamp worker count into 1..MAX_WORKERS.
  always_comb begin
    if (num_workers_r == '0) begin
      p_eff = nw_t'(1);
    end else if (num_workers_r > nw_t'(MAX_WORKERS)) begin
      p_eff = nw_t'(MAX_WORKERS);
    end else begin
      p_eff = num_workers_r;
    end
  end

  assign rd_addr = cmd.scan_step ? idx_r : me_r;
  assign rd_next = rn_r[rd_addr];
  assign rd_end  = re_r[rd_addr];
  assign rd_load = (rd_next < rd_end) ? (rd_end - rd_next) : '0;

  assign div_try = {div_pr_r[NWW-1:0], div_q_r[DW-1]};
  assign div_ge  = (div_try >= {1'b0, p_eff});

  assign chunk  = (div_q_r == '0) ? data_t'(1) : div_q_r;
  assign e_full = {1'b0, rd_next} + {1'b0, chunk};
  assign s_sat  = (rd_next > total_r) ? total_r : rd_next;
  assign e_sat  = (e_full > {1'b0, total_r}) ? total_r : e_full[DW-1:0];

  assign fill_live = ({1'b0, idx_r} < p_eff);
  assign fill_tail = ({1'b0, idx_r} == (p_eff - nw_t'(1)));

  assign sts.div_done  = (div_cnt_r == '0);
  assign sts.idx_last  = (idx_r == wid_t'(MAX_WORKERS - 1));
  assign sts.me_empty  = (rem_r == '0);
  assign sts.best_zero = (best_r == '0);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_workers_r <= RST_NUM_WORKERS;
      total_r       <= RST_TOTAL_ITERS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_WORKERS: num_workers_r <= cfg_wdata[NWW-1:0];
        REG_TOTAL_ITERS: total_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Range table: fill sweep, takeover and grant writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        rn_r[i] <= '0;
        re_r[i] <= '0;
      end
    end else if (cmd.fill_step) begin
      if (fill_live) begin
        rn_r[idx_r] <= acc_r;
        re_r[idx_r] <= fill_tail ? total_r : (acc_r + div_q_r);
      end else begin
        rn_r[idx_r] <= '0;
        re_r[idx_r] <= '0;
      end
    end else if (cmd.take) begin
      rn_r[me_r]     <= best_next_r;
      re_r[me_r]     <= best_end_r;
      rn_r[victim_r] <= '0;
      re_r[victim_r] <= '0;
    end else if (cmd.grant) begin
      rn_r[me_r] <= e_full[DW-1:0];
    end
  end

  // Serial restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_load) begin
      div_cnt_r <= DIV_CW'(DW);
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_pr_r <= '0;
      div_q_r  <= cmd.div_sel_rem ? rem_r : total_r;
    end else if (cmd.div_step) begin
      div_pr_r <= div_ge ? (div_try - {1'b0, p_eff}) : div_try;
      div_q_r  <= {div_q_r[DW-2:0], div_ge};
    end
  end

  // Request bookkeeping: index sweep, load scan and takeover capture.
  always_ff @(posedge clk) begin
    if (cmd.latch && in_worker_id_vld) me_r <= in_worker_id;
    if (cmd.fill_start || cmd.load_me) begin
      idx_r <= '0;
    end else if (cmd.fill_step || cmd.scan_step) begin
      idx_r <= idx_r + wid_t'(1);
    end
    if (cmd.fill_start) begin
      acc_r <= '0;
    end else if (cmd.fill_step) begin
      acc_r <= acc_r + div_q_r;
    end
    if (cmd.load_me) begin
      rem_r    <= rd_load;
      best_r   <= '0;
      victim_r <= '0;
      stolen_r <= 1'b0;
    end else if (cmd.scan_step && (rd_load > best_r)) begin
      best_r      <= rd_load;
      victim_r    <= idx_r;
      best_next_r <= rd_next;
      best_end_r  <= rd_end;
    end else if (cmd.take) begin
      rem_r    <= best_r;
      stolen_r <= 1'b1;
    end
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_start | cmd.emit_done | cmd.grant;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start || cmd.emit_done) begin
      out_start_r    <= '0;
      out_end_r      <= '0;
      out_stolen_r   <= 1'b0;
      out_victim_r   <= '0;
      out_all_done_r <= cmd.emit_done;
    end else if (cmd.grant) begin
      out_start_r    <= s_sat;
      out_end_r      <= e_sat;
      out_stolen_r   <= stolen_r;
      out_victim_r   <= stolen_r ? victim_r : '0;
      out_all_done_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chunk_start = out_start_r;
  assign out_chunk_end   = out_end_r;
  assign out_stolen      = out_stolen_r;
  assign out_victim_id   = out_victim_r;
  assign out_all_done    = out_all_done_r;

endmodule

// File: rtl/affinity_chunk_dispenser.sv
// ----------------------------------------------------------------------------
// affinity_chunk_dispenser
// Work dispenser for affinity loop scheduling with range takeover.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_req_type / in_worker_id and pulse start while busy
//   is low. A start word (type 0) splits [0, total) into one range per worker;
//   a chunk word (type 1) grants part of the worker's range, taking over the
//   most loaded range when its own is empty.
//   Result channel: each word appears for exactly one cycle with out_valid
//   high. The receiver cannot stall; capture the word in that cycle.
//   Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
//   worker count (0) or total iterations (1). Write only while idle.
// Steps per word, accepting edge to out_valid (busy high throughout):
//   start word: serial divide of the total, then a 16-entry fill sweep.
//   chunk word from own range: serial divide of the load.
//   chunk word with takeover: 16-entry load scan, then the divide;
//   done word: load scan only. One word is in flight at a time.
// Reset: all ranges empty, worker count 4, total 729, no result pending.
// ----------------------------------------------------------------------------
module affinity_chunk_dispenser
  import acd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  logic  in_req_type,
  input  wid_t  in_worker_id,
  output logic  out_valid,
  output data_t out_chunk_start,
  output data_t out_chunk_end,
  output logic  out_stolen,
  output wid_t  out_victim_id,
  output logic  out_all_done,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  logic  cfg_index,
  input  data_t cfg_wdata
);

  cmd_t    cmd;
  status_t sts;

  // Config writes land at once; no backpressure.
  assign cfg_ready = 1'b1;

  acd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // Hold the worker id only for chunk words.
  acd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_worker_id_vld (in_req_type == REQ_CHUNK),
    .in_worker_id     (in_worker_id),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_chunk_start  (out_chunk_start),
    .out_chunk_end    (out_chunk_end),
    .out_stolen       (out_stolen),
    .out_victim_id    (out_victim_id),
    .out_all_done     (out_all_done)
  );

endmodule

// File: rtl/acd_checker.sv
// ----------------------------------------------------------------------------
// acd_checker
// Port-level checks on the dispenser, bound to the top level.
// ----------------------------------------------------------------------------
`include "affinity_chunk_dispenser_assert.svh"

module acd_checker
  import acd_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input logic  out_valid,
  input data_t out_chunk_start,
  input data_t out_chunk_end,
  input logic  out_stolen,
  input wid_t  out_victim_id,
  input logic  out_all_done
);

  // An accepted word occupies the block on the next cycle.
  `ACD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // A result word is never shown twice in a row.
  `ACD_ASSERT_NXT(a_single_word, clk, rst_n, out_valid, !out_valid)
  // Done words carry an empty chunk.
  `ACD_ASSERT_IMP(a_done_empty, clk, rst_n, out_valid && out_all_done, (out_chunk_start == '0) && (out_chunk_end == '0) && !out_stolen)
  // Chunk never runs backward; victim only named on takeover.
  `ACD_ASSERT_IMP(a_chunk_order, clk, rst_n, out_valid, (out_chunk_end >= out_chunk_start) && (out_stolen || (out_victim_id == '0)))

endmodule

bind affinity_chunk_dispenser acd_checker u_acd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_chunk_start (out_chunk_start),
  .out_chunk_end   (out_chunk_end),
  .out_stolen      (out_stolen),
  .out_victim_id   (out_victim_id),
  .out_all_done    (out_all_done)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Affinity chunk dispenser testbench
// Drives start and chunk words under changing worker counts and totals, and
// checks every result word against a cycle-free model of the dispenser.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import acd_pkg::*;

  // Scoreboard: holds the dispenser model state and the queue of expected words.
  class chunk_scoreboard;
    typedef struct packed {
      data_t c_start;
      data_t c_end;
      logic  stolen;
      wid_t  victim;
      logic  done;
    } grant_t;

    nw_t    workers_reg;
    data_t  total_reg;
    int     rng_next[MAX_WORKERS];
    int     rng_end[MAX_WORKERS];
    grant_t pending_grants[$];
    int     errors;

    function void clear_state();
      workers_reg = RST_NUM_WORKERS;
      total_reg = RST_TOTAL_ITERS;
      foreach (rng_next[w]) begin
        rng_next[w] = 0;
        rng_end[w] = 0;
      end
      pending_grants.delete();
      errors = 0;
    endfunction

    function int active_workers();
      if (workers_reg == 0) return 1;
      if (workers_reg > MAX_WORKERS) return MAX_WORKERS;
      return workers_reg;
    endfunction

    function int load_of(int w);
      return (rng_next[w] < rng_end[w]) ? rng_end[w] - rng_next[w] : 0;
    endfunction

    // Note an accepted input word and compute the grant it produces.
    function void note_request(logic req, wid_t wid);
      grant_t g;
      int p, seg, rem, best, victim, s, e, me;
      g = '0;
      p = active_workers();
      me = wid;
      if (req == REQ_START) begin
        seg = total_reg / p;
        for (int w = 0; w < MAX_WORKERS; w++) begin
          rng_next[w] = (w < p) ? w * seg : 0;
          rng_end[w] = (w < p) ? ((w == p - 1) ? total_reg : (w + 1) * seg) : 0;
        end
        pending_grants.push_back(g);
        return;
      end
      rem = load_of(me);
      victim = 0;
      if (rem == 0) begin
        best = 0;
        for (int w = 0; w < MAX_WORKERS; w++)
          if (load_of(w) > best) begin
            best = load_of(w);
            victim = w;
          end
        if (best == 0) begin
          g.done = 1'b1;
          pending_grants.push_back(g);
          return;
        end
        rng_next[me] = rng_next[victim];
        rng_end[me] = rng_end[victim];
        rng_next[victim] = 0;
        rng_end[victim] = 0;
        rem = best;
        g.stolen = 1'b1;
        g.victim = wid_t'(victim);
      end
      rem = rem / p;
      if (rem < 1) rem = 1;
      s = rng_next[me];
      e = s + rem;
      rng_next[me] = e & 16'hFFFF;
      if (s > total_reg) s = total_reg;
      if (e > total_reg) e = total_reg;
      g.c_start = data_t'(s);
      g.c_end = data_t'(e);
      pending_grants.push_back(g);
    endfunction

    function void report(string what);
      errors++;
      $display("MISMATCH %0t: %s", $time, what);
    endfunction

    // Check a result word against the oldest expected grant.
    function void check_grant(data_t cs, data_t ce, logic st, wid_t vi, logic dn);
      grant_t g;
      if (pending_grants.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      g = pending_grants.pop_front();
      if (cs !== g.c_start) report($sformatf("chunk_start %0d exp %0d", cs, g.c_start));
      if (ce !== g.c_end) report($sformatf("chunk_end %0d exp %0d", ce, g.c_end));
      if (st !== g.stolen) report($sformatf("stolen %0b exp %0b", st, g.stolen));
      if (vi !== g.victim) report($sformatf("victim_id %0d exp %0d", vi, g.victim));
      if (dn !== g.done) report($sformatf("all_done %0b exp %0b", dn, g.done));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  in_req_type;
  wid_t  in_worker_id;
  logic  out_valid;
  data_t out_chunk_start;
  data_t out_chunk_end;
  logic  out_stolen;
  wid_t  out_victim_id;
  logic  out_all_done;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_index;
  data_t cfg_wdata;

  chunk_scoreboard board;
  int idle_pct;
  int stall_cycles;

  affinity_chunk_dispenser i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check result words; the receiver never stalls, so sample every strobe.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_grant(out_chunk_start, out_chunk_end, out_stolen, out_victim_id,
                        out_all_done);
  end

  // Watchdog: count cycles with no accepted word on either channel and no result word.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one input word; idle first at the current rate, hold start until taken.
  // Drop start after the accepting edge; it stays low until the next word.
  task automatic send_word(logic req, wid_t wid);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_req_type <= req;
    in_worker_id <= wid;
    do @(posedge clk); while (busy);
    board.note_request(req, wid);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all expected words, then let the block settle before config.
  task automatic drain();
    while (board.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, data_t val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_WORKERS) board.workers_reg = nw_t'(val);
    else board.total_reg = val;
  endtask

  // One run: partition, then mostly chunk requests from random workers.
  task automatic run_phase(int n_words, int id_span);
    send_word(REQ_START, wid_t'($urandom));
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(29) == 0) send_word(REQ_START, wid_t'($urandom));
      else send_word(REQ_CHUNK, wid_t'($urandom_range(id_span)));
    end
  endtask

  initial begin
    board = new();
    board.clear_state();
    stall_cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_START;
    in_worker_id = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NUM_WORKERS;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: chunk before any start answers done; default config runs.
    send_word(REQ_CHUNK, wid_t'(0));
    send_word(REQ_START, wid_t'(15));
    for (int i = 0; i < 6; i++) send_word(REQ_CHUNK, wid_t'(3));
    send_word(REQ_CHUNK, wid_t'(15));
    send_word(REQ_CHUNK, wid_t'(9));
    // Zero total: the start word leaves empty ranges and the chunk request answers done.
    write_reg(REG_TOTAL_ITERS, 16'd0);
    send_word(REQ_START, wid_t'(0));
    send_word(REQ_CHUNK, wid_t'(1));
    // Zero workers counts as one; a tiny total drains to done.
    write_reg(REG_NUM_WORKERS, 16'd0);
    write_reg(REG_TOTAL_ITERS, 16'd3);
    send_word(REQ_START, wid_t'(0));
    for (int i = 0; i < 5; i++) send_word(REQ_CHUNK, wid_t'(i * 5));
    // Worker count above the maximum, full total.
    write_reg(REG_NUM_WORKERS, 16'd31);
    write_reg(REG_TOTAL_ITERS, 16'hFFFF);
    send_word(REQ_START, wid_t'(0));
    send_word(REQ_CHUNK, wid_t'(15));
    send_word(REQ_CHUNK, wid_t'(0));
    // Shrink the total under live ranges to hit saturation.
    write_reg(REG_TOTAL_ITERS, 16'd100);
    send_word(REQ_CHUNK, wid_t'(15));
    send_word(REQ_CHUNK, wid_t'(7));

    // Random phases: sender idles 18%, then 52%, then never.
    for (int ph = 0; ph < 15; ph++) begin
      idle_pct = (ph < 5) ? 18 : (ph < 10) ? 52 : 0;
      write_reg(REG_NUM_WORKERS, data_t'($urandom_range(ph % 4 == 0 ? 31 : 16)));
      write_reg(REG_TOTAL_ITERS,
                ph % 5 == 4 ? 16'hFFFF - data_t'($urandom_range(3))
                            : data_t'($urandom_range(ph % 2 ? 300 : 40)));
      run_phase(30, (ph % 3 == 0) ? 15 : $urandom_range(15));
    end

    drain();
    if (board.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
